// ===== hdl/spc_pkg.sv =====
// Shared types and constants of the scan point to Cartesian unit.
// Depends on nothing; every other file imports it.
package spc_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int XY_W = 33;
    localparam int Z_W  = 27;
    localparam int CS_W = 20;
    localparam int CFG_W = 16;
    localparam int OUT_W = 18;
    localparam int CFG_IDX_W = 3;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

    // Elementary angles atan(2^-i) in Q.24.
    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        27'sd13176795, 27'sd7778716, 27'sd4110060, 27'sd2086331,
        27'sd1047214, 27'sd524117, 27'sd262123, 27'sd131069,
        27'sd65536, 27'sd32768, 27'sd16384, 27'sd8192,
        27'sd4096, 27'sd2048, 27'sd1024, 27'sd512,
        27'sd256, 27'sd128, 27'sd64, 27'sd32,
        27'sd16, 27'sd8, 27'sd4, 27'sd2
    };

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOUNT_COS = 3'd0,
        REG_MOUNT_SIN = 3'd1,
        REG_ORIGIN_X  = 3'd2,
        REG_ORIGIN_Y  = 3'd3,
        REG_ORIGIN_Z  = 3'd4
    } cfg_reg_t;

    // One rotator's working vector.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_vec_t;

    // Both angles of one scan point travel together.
    typedef struct packed {
        cordic_vec_t ax;
        cordic_vec_t ay;
    } cordic_pair_t;

endpackage

// ===== hdl/spc_if.sv =====
// Valid/ready channel interfaces for scan points in and Cartesian points out.
// Depends on spc_pkg for the output width.
interface spc_in_if #(
    parameter int ANGLE_BITS = 24,
    parameter int RANGE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] raw_angle_x;
    logic [ANGLE_BITS-1:0] raw_angle_y;
    logic [RANGE_BITS-1:0] distance;

    modport source (output valid, raw_angle_x, raw_angle_y, distance, input ready);
    modport sink   (input valid, raw_angle_x, raw_angle_y, distance, output ready);
endinterface

interface spc_out_if;
    import spc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] x_pos;
    logic signed [OUT_W-1:0] y_pos;
    logic signed [OUT_W-1:0] z_pos;
    logic                    clipped;

    modport source (output valid, x_pos, y_pos, z_pos, clipped, input ready);
    modport sink   (input valid, x_pos, y_pos, z_pos, clipped, output ready);
endinterface

// ===== hdl/spc_cordic_stage.sv =====
// One registered CORDIC rotation step applied to both angles of a point.
// Depends on spc_pkg for the vector types and the arctangent table.
module spc_cordic_stage #(
    parameter int STEP = 0,
    parameter int RANGE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  spc_pkg::cordic_pair_t in_data,
    input  logic [RANGE_BITS-1:0] in_dist,
    output logic                  out_valid,
    input  logic                  out_ready,
    output spc_pkg::cordic_pair_t out_data,
    output logic [RANGE_BITS-1:0] out_dist
);
    import spc_pkg::*;

    logic                  valid_reg;
    cordic_pair_t          data_reg;
    cordic_pair_t          data_next;
    logic [RANGE_BITS-1:0] dist_reg;

    function automatic cordic_vec_t rotate(input cordic_vec_t v);
        cordic_vec_t r;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        dx = v.y >>> STEP;
        dy = v.x >>> STEP;
        if (!v.z[Z_W-1])
        begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - ATAN_TAB[STEP];
        end
        else
        begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + ATAN_TAB[STEP];
        end
        return r;
    endfunction

    // Rotate both vectors toward zero residual angle.
    always_comb
    begin
        data_next.ax = rotate(in_data.ax);
        data_next.ay = rotate(in_data.ay);
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage register; holds while the next stage is full and stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
            dist_reg <= in_dist;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_dist  = dist_reg;

endmodule

// ===== hdl/spc_project.sv =====
// Projection back end: products of sines and cosines with range, tilt rotation,
// origin offsets, rounding and saturation, in six registered stages. Uses spc_pkg.
module spc_project #(
    parameter int RANGE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  spc_pkg::cordic_pair_t          in_data,
    input  logic [RANGE_BITS-1:0]          in_dist,
    input  logic signed [spc_pkg::CFG_W-1:0] mount_cos,
    input  logic signed [spc_pkg::CFG_W-1:0] mount_sin,
    input  logic signed [spc_pkg::CFG_W-1:0] origin_x,
    input  logic signed [spc_pkg::CFG_W-1:0] origin_y,
    input  logic signed [spc_pkg::CFG_W-1:0] origin_z,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [spc_pkg::OUT_W-1:0] x_pos,
    output logic signed [spc_pkg::OUT_W-1:0] y_pos,
    output logic signed [spc_pkg::OUT_W-1:0] z_pos,
    output logic                           clipped
);
    import spc_pkg::*;

    localparam int NST   = 6;
    localparam int D_W   = RANGE_BITS + 1;
    localparam int CC_W  = 2 * CS_W;
    localparam int TXF_W = CC_W + D_W;
    localparam int TX_W  = TXF_W - 18;
    localparam int TZ_W  = D_W + CS_W;
    localparam int M_W   = TX_W + CFG_W;
    localparam int V_W   = (M_W + 2 > 51) ? M_W + 2 : 51;
    localparam int RX_W  = V_W - 33;
    localparam int Y_W   = ((TX_W > 35) ? TX_W : 35) + 1;
    localparam int RY_W  = Y_W - 18;

    logic [NST-1:0] valid_reg;
    logic [NST:0]   rdy;

    // Each stage advances when empty or when the stage after it advances.
    assign rdy[NST] = out_ready;
    for (genvar k = 0; k < NST; k++)
    begin : g_rdy
        assign rdy[k] = !valid_reg[k] || rdy[k+1];
    end
    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0]) valid_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
            begin
                if (rdy[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    logic [NST-1:0] load;
    assign load[0] = rdy[0] && in_valid;
    for (genvar k = 1; k < NST; k++)
    begin : g_load
        assign load[k] = rdy[k] && valid_reg[k-1];
    end

    // Stage A: round CORDIC outputs to Q.18 and form the angle products.
    logic signed [XY_W-1:0] cxs, sxs, cys, sys;
    logic signed [CS_W-1:0] cx, sx, cy, sy;
    assign cxs = in_data.ax.x + XY_W'(2048);
    assign sxs = in_data.ax.y + XY_W'(2048);
    assign cys = in_data.ay.x + XY_W'(2048);
    assign sys = in_data.ay.y + XY_W'(2048);
    assign cx = cxs[CS_W+11:12];
    assign sx = sxs[CS_W+11:12];
    assign cy = cys[CS_W+11:12];
    assign sy = sys[CS_W+11:12];

    logic signed [CC_W-1:0] a_cc_reg, a_sc_reg;
    logic signed [TZ_W-1:0] a_tz_reg;
    logic signed [D_W-1:0]  a_d_reg;
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            a_cc_reg <= cx * cy;
            a_sc_reg <= sx * cy;
            a_tz_reg <= $signed({1'b0, in_dist}) * sy;
            a_d_reg  <= $signed({1'b0, in_dist});
        end
    end

    // Stage B: scale by range.
    logic signed [TXF_W-1:0] b_txf_reg, b_tyf_reg;
    logic signed [TZ_W-1:0]  b_tz_reg;
    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            b_txf_reg <= a_cc_reg * a_d_reg;
            b_tyf_reg <= a_sc_reg * a_d_reg;
            b_tz_reg  <= a_tz_reg;
        end
    end

    // Stage C: round the spherical x and y back to Q.18.
    logic signed [TXF_W-1:0] txr, tyr;
    assign txr = (b_txf_reg + TXF_W'(131072)) >>> 18;
    assign tyr = (b_tyf_reg + TXF_W'(131072)) >>> 18;
    logic signed [TX_W-1:0] c_tx_reg, c_ty_reg;
    logic signed [TZ_W-1:0] c_tz_reg;
    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            c_tx_reg <= txr[TX_W-1:0];
            c_ty_reg <= tyr[TX_W-1:0];
            c_tz_reg <= b_tz_reg;
        end
    end

    // Stage D: tilt rotation products.
    logic signed [M_W-1:0] d_zs_reg, d_xc_reg, d_zc_reg, d_xs_reg;
    logic signed [TX_W-1:0] d_ty_reg;
    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            d_zs_reg <= M_W'(c_tz_reg * mount_sin);
            d_xc_reg <= M_W'(c_tx_reg * mount_cos);
            d_zc_reg <= M_W'(c_tz_reg * mount_cos);
            d_xs_reg <= M_W'(c_tx_reg * mount_sin);
            d_ty_reg <= c_ty_reg;
        end
    end

    // Stage E: sums with offsets, rounded to integers (ties upward).
    logic signed [V_W-1:0] vx, vz;
    logic signed [Y_W-1:0] vy;
    assign vx = (V_W'(d_zs_reg) + V_W'(d_xc_reg) + (V_W'(origin_x) <<< 33)
                 + (V_W'(1) <<< 32)) >>> 33;
    assign vz = (V_W'(d_zc_reg) - V_W'(d_xs_reg) + (V_W'(origin_z) <<< 33)
                 + (V_W'(1) <<< 32)) >>> 33;
    assign vy = (Y_W'(d_ty_reg) + (Y_W'(origin_y) <<< 18) + Y_W'(131072)) >>> 18;
    logic signed [RX_W-1:0] e_x_reg, e_z_reg;
    logic signed [RY_W-1:0] e_y_reg;
    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            e_x_reg <= vx[RX_W-1:0];
            e_z_reg <= vz[RX_W-1:0];
            e_y_reg <= vy[RY_W-1:0];
        end
    end

    // Stage F: saturate to the output range and flag clipping.
    localparam logic signed [RX_W-1:0] XMAX = RX_W'(OUT_MAX);
    localparam logic signed [RX_W-1:0] XMIN = RX_W'(OUT_MIN);
    localparam logic signed [RY_W-1:0] YMAX = RY_W'(OUT_MAX);
    localparam logic signed [RY_W-1:0] YMIN = RY_W'(OUT_MIN);
    logic signed [OUT_W-1:0] sx_n, sy_n, sz_n;
    logic clip_x, clip_y, clip_z;
    always_comb
    begin
        clip_x = (e_x_reg > XMAX) || (e_x_reg < XMIN);
        clip_y = (e_y_reg > YMAX) || (e_y_reg < YMIN);
        clip_z = (e_z_reg > XMAX) || (e_z_reg < XMIN);
        sx_n = (e_x_reg > XMAX) ? OUT_MAX : (e_x_reg < XMIN) ? OUT_MIN : e_x_reg[OUT_W-1:0];
        sy_n = (e_y_reg > YMAX) ? OUT_MAX : (e_y_reg < YMIN) ? OUT_MIN : e_y_reg[OUT_W-1:0];
        sz_n = (e_z_reg > XMAX) ? OUT_MAX : (e_z_reg < XMIN) ? OUT_MIN : e_z_reg[OUT_W-1:0];
    end

    logic signed [OUT_W-1:0] f_x_reg, f_y_reg, f_z_reg;
    logic f_clip_reg;
    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            f_x_reg    <= sx_n;
            f_y_reg    <= sy_n;
            f_z_reg    <= sz_n;
            f_clip_reg <= clip_x || clip_y || clip_z;
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign x_pos     = f_x_reg;
    assign y_pos     = f_y_reg;
    assign z_pos     = f_z_reg;
    assign clipped   = f_clip_reg;

    // A clip flag always comes with a coordinate at a bound.
    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> x_pos == OUT_MAX || x_pos == OUT_MIN ||
        y_pos == OUT_MAX || y_pos == OUT_MIN || z_pos == OUT_MAX || z_pos == OUT_MIN)
        else $error("clip flag without saturated coordinate");

    // A full stage C that cannot advance keeps its item.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] && !rdy[2] |=> valid_reg[2])
        else $error("stalled item lost in back end");

    // A request taken at the input lands in the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted request missing from first stage");

endmodule

// ===== hdl/scan_point_to_cartesian_unit.sv =====
// Scan point to Cartesian unit: CORDIC pipeline, projection and tilt rotation.
// The pipeline has 24 CORDIC stages (one step each) and 6 back end stages.
// Throughput one point per cycle; a stalled output holds each stage in place.
// Reset clears all valid bits and loads the mounting registers for a 70 degree tilt.
// Depends on spc_pkg, spc_if, spc_cordic_stage and spc_project.
module scan_point_to_cartesian_unit #(
    parameter int ANGLE_BITS = 24,
    parameter int RANGE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    spc_in_if.sink                             pt_in,
    spc_out_if.source                          pt_out,
    input  logic                               cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [spc_pkg::CFG_W-1:0]          cfg_data
);
    import spc_pkg::*;

    localparam int SH_W = ANGLE_BITS + 13;

    // Configuration registers.
    logic signed [CFG_W-1:0] mount_cos_reg, mount_sin_reg;
    logic signed [CFG_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mount_cos_reg <= 16'sd11207;
            mount_sin_reg <= 16'sd30792;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            origin_z_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MOUNT_COS: mount_cos_reg <= cfg_data;
                REG_MOUNT_SIN: mount_sin_reg <= cfg_data;
                REG_ORIGIN_X:  origin_x_reg  <= cfg_data;
                REG_ORIGIN_Y:  origin_y_reg  <= cfg_data;
                REG_ORIGIN_Z:  origin_z_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Angle code to Q.24 radians: floor(code * 2^(25-ANGLE_BITS)) - 2^24.
    logic [SH_W-1:0] shx, shy;
    logic signed [Z_W-1:0] thx, thy;
    assign shx = {pt_in.raw_angle_x, 13'b0} >> (ANGLE_BITS - 12);
    assign shy = {pt_in.raw_angle_y, 13'b0} >> (ANGLE_BITS - 12);
    assign thx = $signed({2'b00, shx[24:0]}) - (Z_W'(1) <<< 24);
    assign thy = $signed({2'b00, shy[24:0]}) - (Z_W'(1) <<< 24);

    cordic_pair_t          c_data [CORDIC_STEPS+1];
    logic [RANGE_BITS-1:0] c_dist [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] c_valid;
    logic [CORDIC_STEPS:0] c_ready;

    assign c_data[0].ax = '{x: CORDIC_GAIN, y: '0, z: thx};
    assign c_data[0].ay = '{x: CORDIC_GAIN, y: '0, z: thy};
    assign c_dist[0]    = pt_in.distance;
    assign c_valid[0]   = pt_in.valid;
    assign pt_in.ready  = c_ready[0];

    // CORDIC pipeline, one rotation step per stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        spc_cordic_stage #(.STEP(i), .RANGE_BITS(RANGE_BITS)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .in_data   (c_data[i]),
            .in_dist   (c_dist[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .out_data  (c_data[i+1]),
            .out_dist  (c_dist[i+1])
        );
    end

    // Projection, rotation and output stages.
    spc_project #(.RANGE_BITS(RANGE_BITS)) u_project (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid[CORDIC_STEPS]),
        .in_ready  (c_ready[CORDIC_STEPS]),
        .in_data   (c_data[CORDIC_STEPS]),
        .in_dist   (c_dist[CORDIC_STEPS]),
        .mount_cos (mount_cos_reg),
        .mount_sin (mount_sin_reg),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .origin_z  (origin_z_reg),
        .out_valid (pt_out.valid),
        .out_ready (pt_out.ready),
        .x_pos     (pt_out.x_pos),
        .y_pos     (pt_out.y_pos),
        .z_pos     (pt_out.z_pos),
        .clipped   (pt_out.clipped)
    );

    // The handoff into the back end holds while it is stalled.
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid[CORDIC_STEPS] && !c_ready[CORDIC_STEPS] |=> c_valid[CORDIC_STEPS])
        else $error("CORDIC output dropped while back end stalled");

    // The residual x angle after the first step stays strictly inside plus or minus 2^25 in Q.24.
    a_first_z: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid[1] |-> c_data[1].ax.z < (Z_W'(1) <<< 25) && c_data[1].ax.z > -(Z_W'(1) <<< 25))
        else $error("CORDIC residual out of range");

    // An empty CORDIC front stage always accepts.
    a_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !c_valid[1] |-> c_ready[0])
        else $error("empty front stage refused a request");

endmodule

// ===== test/scan_point_to_cartesian_unit_tb.sv =====
// Testbench of scan_point_to_cartesian_unit: random and directed scan points with a
// bit-exact CORDIC and rotation predictor, random idling on both channels.
// Depends on spc_pkg, spc_if and the unit under test.
module scan_point_to_cartesian_unit_tb;
    import spc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_BITS = 24;
    localparam int RANGE_BITS = 16;
    localparam int LAT_CYCLES = 40;
    localparam int LONG_HOLD = 300;
    localparam longint CYCLE_LIMIT = 600000;

    typedef struct {
        logic [ANGLE_BITS-1:0] ax;
        logic [ANGLE_BITS-1:0] ay;
        logic [RANGE_BITS-1:0] rng;
    } scan_point_t;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic                    clip;
    } cart_point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    spc_in_if #(.ANGLE_BITS(ANGLE_BITS), .RANGE_BITS(RANGE_BITS)) in_ch ();
    spc_out_if out_ch ();

    scan_point_to_cartesian_unit #(.ANGLE_BITS(ANGLE_BITS), .RANGE_BITS(RANGE_BITS)) dut (
        .clk(clk), .rst_n(rst_n), .pt_in(in_ch), .pt_out(out_ch),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Mirror of the tilt and origin registers.
    longint tilt_cos, tilt_sin, off_x, off_y, off_z;

    scan_point_t pending_points[$];
    cart_point_t expected_points[$];
    bit no_idle = 1'b0;
    int hold_requests = 0;
    int holds_served = 0;
    int mismatches = 0;
    longint cycles = 0;

    // Rotation-mode CORDIC giving cos and sin in Q.18.
    task automatic cordic_sincos(input longint theta, output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = 652032874;
        y = 0;
        z = theta;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
        c = (x + 2048) >>> 12;
        s = (y + 2048) >>> 12;
    endtask

    function automatic logic signed [OUT_W-1:0] clamp18(input longint v, inout logic clip);
        if (v > 131071)
        begin
            clip = 1'b1;
            return OUT_MAX;
        end
        if (v < -131072)
        begin
            clip = 1'b1;
            return OUT_MIN;
        end
        return v[OUT_W-1:0];
    endfunction

    // Expected Cartesian point for one scan point under the current registers.
    task automatic project_point(input scan_point_t p, output cart_point_t r);
        longint cx, sx, cy, sy, d, tx, ty, tz, vx, vy, vz;
        logic clip;
        clip = 1'b0;
        d = longint'(p.rng);
        cordic_sincos(longint'(p.ax) * 2 - (longint'(1) << 24), cx, sx);
        cordic_sincos(longint'(p.ay) * 2 - (longint'(1) << 24), cy, sy);
        tx = (d * cx * cy + (longint'(1) << 17)) >>> 18;
        ty = (d * sx * cy + (longint'(1) << 17)) >>> 18;
        tz = d * sy;
        vx = tz * tilt_sin + tx * tilt_cos + off_x * (longint'(1) << 33);
        vz = tz * tilt_cos - tx * tilt_sin + off_z * (longint'(1) << 33);
        vy = ty + off_y * (longint'(1) << 18);
        r.x = clamp18((vx + (longint'(1) << 32)) >>> 33, clip);
        r.y = clamp18((vy + (longint'(1) << 17)) >>> 18, clip);
        r.z = clamp18((vz + (longint'(1) << 32)) >>> 33, clip);
        r.clip = clip;
    endtask

    // Register write; the mirror follows because the unit is idle.
    task automatic write_reg(input int idx, input logic [CFG_W-1:0] val);
        longint v;
        v = longint'(signed'(val));
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx[CFG_IDX_W-1:0];
        cfg_data <= val;
        case (idx)
            REG_MOUNT_COS: tilt_cos = v;
            REG_MOUNT_SIN: tilt_sin = v;
            REG_ORIGIN_X: off_x = v;
            REG_ORIGIN_Y: off_y = v;
            REG_ORIGIN_Z: off_z = v;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input int c, input int s, input int ox, input int oy, input int oz);
        write_reg(REG_MOUNT_COS, c[CFG_W-1:0]);
        write_reg(REG_MOUNT_SIN, s[CFG_W-1:0]);
        write_reg(REG_ORIGIN_X, ox[CFG_W-1:0]);
        write_reg(REG_ORIGIN_Y, oy[CFG_W-1:0]);
        write_reg(REG_ORIGIN_Z, oz[CFG_W-1:0]);
    endtask

    task automatic add_point(input logic [ANGLE_BITS-1:0] ax, input logic [ANGLE_BITS-1:0] ay,
                             input logic [RANGE_BITS-1:0] rng);
        scan_point_t p;
        p.ax = ax;
        p.ay = ay;
        p.rng = rng;
        pending_points.push_back(p);
    endtask

    // Random points; ranges near the extremes now and then to reach saturation.
    task automatic add_random_points(input int n);
        logic [RANGE_BITS-1:0] rng;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 5))
                0: rng = 16'hFFFF - 16'($urandom_range(0, 63));
                1: rng = 16'($urandom_range(0, 15));
                default: rng = 16'($urandom);
            endcase
            add_point(24'($urandom), 24'($urandom), rng);
        end
    endtask

    task automatic wait_drained;
        while (pending_points.size() != 0 || in_ch.valid || expected_points.size() != 0)
            @(posedge clk);
        repeat (LAT_CYCLES) @(posedge clk);
    endtask

    // Request driver: takes the next pending point, with random idle bursts.
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        cart_point_t r;
        scan_point_t p;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.raw_angle_x <= '0;
            in_ch.raw_angle_y <= '0;
            in_ch.distance <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                p.ax = in_ch.raw_angle_x;
                p.ay = in_ch.raw_angle_y;
                p.rng = in_ch.distance;
                project_point(p, r);
                expected_points.push_back(r);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_points.size() != 0)
                begin
                    p = pending_points.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.raw_angle_x <= p.ax;
                    in_ch.raw_angle_y <= p.ay;
                    in_ch.distance <= p.rng;
                    if (!no_idle && $urandom_range(0, 15) == 0)
                        send_gap = $urandom_range(1, 11);
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: random stall bursts, long holds on request, field checks.
    int stall_gap = 0;
    int hold_cnt = 0;
    always @(posedge clk or negedge rst_n)
    begin
        cart_point_t e;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_gap = 0;
            hold_cnt = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected point x=%0d y=%0d z=%0d clip=%0b",
                                 out_ch.x_pos, out_ch.y_pos, out_ch.z_pos, out_ch.clipped);
                end
                else
                begin
                    e = expected_points.pop_front();
                    if (out_ch.x_pos !== e.x || out_ch.y_pos !== e.y ||
                        out_ch.z_pos !== e.z || out_ch.clipped !== e.clip)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected x=%0d y=%0d z=%0d clip=%0b, got x=%0d y=%0d z=%0d clip=%0b",
                                     e.x, e.y, e.z, e.clip,
                                     out_ch.x_pos, out_ch.y_pos, out_ch.z_pos, out_ch.clipped);
                    end
                end
            end
            if (hold_cnt == 0 && holds_served < hold_requests)
            begin
                holds_served++;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_gap > 0)
            begin
                stall_gap--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 15) == 0)
                    stall_gap = $urandom_range(1, 11);
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("scan_point_to_cartesian_unit_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [ANGLE_BITS-1:0] corner [4];
        logic [RANGE_BITS-1:0] dists [3];
        corner = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h400000};
        dists = '{16'h0000, 16'hFFFF, 16'h8000};
        tilt_cos = 11207;
        tilt_sin = 30792;
        off_x = 0;
        off_y = 0;
        off_z = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed corners of both angles and the range, reset registers.
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                add_point(corner[i], corner[j], dists[(i + j) % 3]);
        add_point(24'hFFFFFF, 24'h000000, 16'hFFFF);
        add_point(24'h000001, 24'h7FFFFF, 16'h0001);
        wait_drained();

        // Unknown register indexes must be ignored.
        for (int k = REG_ORIGIN_Z + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(k, 16'($urandom));
        add_random_points(200);
        // Long receiver hold while the sender keeps offering.
        @(posedge clk);
        hold_requests = hold_requests + 1;
        wait_drained();

        // Unit tilt, no offsets.
        set_regs(32767, 0, 0, 0, 0);
        add_random_points(200);
        wait_drained();

        // Most negative gains with largest offsets: heavy saturation.
        set_regs(-32768, -32768, 32767, 32767, 32767);
        for (int i = 0; i < 4; i++)
            add_point(corner[i], corner[3 - i], 16'hFFFF);
        add_random_points(200);
        wait_drained();

        set_regs(32767, 32767, -32768, -32768, -32768);
        add_random_points(200);
        wait_drained();

        // Random registers, several times; the last part runs without idling.
        for (int ph = 0; ph < 4; ph++)
        begin
            set_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
            if (ph == 3)
                no_idle = 1'b1;
            add_random_points(150);
            wait_drained();
        end

        if (mismatches == 0 && expected_points.size() == 0)
            $display("scan_point_to_cartesian_unit_tb: done, clean");
        else
            $display("scan_point_to_cartesian_unit_tb: done, errors");
        $finish;
    end
endmodule
